>>> rtl/myers_shortest_edit_script_assert.svh
// ----------------------------------------------------------------------------
// myers shortest edit script assertion macros
// shared property forms used by the rtl assertions
// ----------------------------------------------------------------------------
`ifndef MYERS_SHORTEST_EDIT_SCRIPT_ASSERT_SVH
`define MYERS_SHORTEST_EDIT_SCRIPT_ASSERT_SVH

// same-cycle implication
`define MSES_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSES_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mses_pkg.sv
// ----------------------------------------------------------------------------
// mses_pkg
// types, sizes and codes of the shortest edit script block
// ----------------------------------------------------------------------------
package mses_pkg;

  localparam int MAX_LEN      = 1024;
  localparam int MAX_EDITS    = 256;
  localparam int SYMBOL_WIDTH = 32;

  localparam int AW        = $clog2(MAX_LEN);
  localparam int CW        = $clog2(MAX_LEN + 1);
  localparam int DW        = $clog2(MAX_EDITS + 1);
  localparam int LIM_W     = 9;
  localparam int TBL_DEPTH = (MAX_EDITS + 1) * (MAX_EDITS + 2) / 2;
  localparam int TW        = $clog2(TBL_DEPTH);
  localparam int PW        = $clog2(MAX_LEN + MAX_EDITS + 2) + 1;
  localparam int SNK_W     = CW + 1;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_OLD     = 3'd1,
    OP_NEW     = 3'd2,
    OP_COMPUTE = 3'd3,
    OP_FETCH   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_EQUAL  = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic [SYMBOL_WIDTH-1:0] symbol;
  } in_word_t;

  typedef struct packed {
    kind_t          kind;
    logic [AW-1:0]  from_pos;
    logic [AW-1:0]  to_pos;
    logic [DW-1:0]  edit_distance;
    status_t        status;
    logic           last;
  } out_word_t;

endpackage

>>> rtl/mses_ram.sv
// ----------------------------------------------------------------------------
// mses_ram
// generic simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module mses_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/myers_shortest_edit_script.sv
// ----------------------------------------------------------------------------
// myers_shortest_edit_script
// greedy diagonal search for the shortest edit script of two token lists
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall/in_data carries one op word; the result
// channel out_valid/out_stall/out_data carries at most one word per op.
// clear and append give no word, except an append at capacity, which gives
// an overflow status.
// compute runs the search through one shared step unit: a diagonal after the
// first reads the furthest-x ram twice (rda, rdb), picks its start in sel,
// walks its snake through snk_rd and snk_cmp and writes its result in vwr;
// backtrack steps each edit through rda, rdb and sel. the status word
// follows, then the input is taken again.
// fetch gives one script row via emit, and via adv_rd and adv_cap when the
// cursor moves on to the next snake (one read of the snake ram).
// the result sits in an output register; while out_stall is high the block
// still takes one more word, parks its result and then stalls the input.
// cfg_valid/cfg_ready writes edit_limit, taken any cycle.
// reset (rst_n low, synchronous) empties both lists, clears the overflow
// flag, drops the script and sets edit_limit to 256; the rams keep their
// contents and are read only where written.
// ----------------------------------------------------------------------------
module myers_shortest_edit_script (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mses_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mses_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data
);
  import mses_pkg::*;

  `include "myers_shortest_edit_script_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_EMIT    = 10'b0000000010,
    S_RDA     = 10'b0000000100,
    S_RDB     = 10'b0000001000,
    S_SEL     = 10'b0000010000,
    S_SNK_RD  = 10'b0000100000,
    S_SNK_CMP = 10'b0001000000,
    S_VWR     = 10'b0010000000,
    S_ADV_RD  = 10'b0100000000,
    S_ADV_CAP = 10'b1000000000
  } state_t;

  typedef logic signed [PW-1:0] pos_t;

  function automatic pos_t ext_cnt(input logic [CW-1:0] v);
    ext_cnt = $signed({{(PW-CW){1'b0}}, v});
  endfunction

  function automatic pos_t ext_d(input logic [DW-1:0] v);
    ext_d = $signed({{(PW-DW){1'b0}}, v});
  endfunction

  // row offset of diagonal k: k or -k-1
  function automatic logic [PW-1:0] diag_ix(input pos_t k);
    diag_ix = (k >= 0) ? k : ~k;
  endfunction

  function automatic out_word_t mk_status(input status_t st, input logic [DW-1:0] ed);
    out_word_t w;
    w.kind          = KIND_STATUS;
    w.from_pos      = '0;
    w.to_pos        = '0;
    w.edit_distance = ed;
    w.status        = st;
    w.last          = 1'b0;
    mk_status = w;
  endfunction

  state_t            state_r, state_nxt;
  logic [LIM_W-1:0]  limit_r;
  logic [CW-1:0]     n_r, n_nxt, m_r, m_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DW-1:0]     lim_r, lim_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  pos_t              k_r, k_nxt, x_r, x_nxt, y_r, y_nxt, lx_r, lx_nxt, ly_r, ly_nxt;
  logic [TW-1:0]     base_r, base_nxt;
  logic              bt_r, bt_nxt;
  logic              oka_r, oka_nxt, okb_r, okb_nxt;
  logic [CW-1:0]     va_r, va_nxt;
  logic [CW-1:0]     prefix_r, prefix_nxt;
  logic [DW-1:0]     dist_r, dist_nxt;
  logic              ready_r, ready_nxt, cp_r, cp_nxt, right_r, right_nxt;
  logic [DW-1:0]     seg_r, seg_nxt, edits_r, edits_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [AW-1:0]     from_r, from_nxt, to_r, to_nxt;
  logic              adv_r, adv_nxt;
  out_word_t         res_r, res_nxt, out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic                    old_we, new_we, v_we, s_we;
  logic [AW-1:0]           st_waddr, old_raddr, new_raddr;
  logic [SYMBOL_WIDTH-1:0] old_rdata, new_rdata;
  logic [TW-1:0]           v_waddr, v_raddr;
  logic [CW-1:0]           v_wdata, v_rdata;
  logic [DW-1:0]           s_waddr, s_raddr;
  logic [SNK_W-1:0]        s_wdata, s_rdata;

  logic              accept, out_free;
  logic [TW-1:0]     prev_base;
  pos_t              kk, vb, va_p, sx, sy, mx, eq, k_step;
  logic [PW-1:0]     ixk;
  logic              up, in_rng;
  logic [CW-1:0]     vb_c, rem_post;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign prev_base = base_r - TW'(d_r);
  assign vb_c      = okb_r ? v_rdata : '0;
  assign vb        = ext_cnt(vb_c);
  assign va_p      = ext_cnt(va_r);
  assign up        = (k_r == -ext_d(d_r)) || ((k_r != ext_d(d_r)) && (va_r < vb_c));
  assign k_step    = up ? (k_r + pos_t'(1)) : (k_r - pos_t'(1));
  assign sx        = up ? vb : va_p;
  assign sy        = sx - k_step;
  assign mx        = up ? sx : (sx + pos_t'(1));
  assign eq        = lx_r - mx;
  assign ixk       = diag_ix(k_r);
  assign in_rng    = (x_r >= 0) && (y_r >= 0) && (x_r < ext_cnt(n_r)) && (y_r < ext_cnt(m_r));

  assign st_waddr  = accept && (in_data.op == OP_OLD) ? n_r[AW-1:0] : m_r[AW-1:0];
  assign old_we    = accept && (in_data.op == OP_OLD) && (n_r < CW'(MAX_LEN));
  assign new_we    = accept && (in_data.op == OP_NEW) && (m_r < CW'(MAX_LEN));
  assign old_raddr = x_r[AW-1:0];
  assign new_raddr = y_r[AW-1:0];

  assign v_we      = (state_r == S_VWR);
  assign v_waddr   = base_r + TW'(ixk);
  assign v_wdata   = x_r[CW-1:0];
  assign kk        = (state_r == S_RDA) ? (k_r - pos_t'(1)) : (k_r + pos_t'(1));
  assign v_raddr   = prev_base + TW'(diag_ix(kk));

  assign s_we      = (state_r == S_SEL) && bt_r;
  assign s_waddr   = d_r;
  assign s_wdata   = {!up, (eq < 0) ? CW'(0) : eq[CW-1:0]};
  assign s_raddr   = seg_r + DW'(1);

  mses_ram #(.WIDTH(SYMBOL_WIDTH), .DEPTH(MAX_LEN)) u_old_ram (
    .clk(clk), .we(old_we), .waddr(st_waddr), .wdata(in_data.symbol),
    .raddr(old_raddr), .rdata(old_rdata)
  );

  mses_ram #(.WIDTH(SYMBOL_WIDTH), .DEPTH(MAX_LEN)) u_new_ram (
    .clk(clk), .we(new_we), .waddr(st_waddr), .wdata(in_data.symbol),
    .raddr(new_raddr), .rdata(new_rdata)
  );

  mses_ram #(.WIDTH(CW), .DEPTH(TBL_DEPTH)) u_v_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  mses_ram #(.WIDTH(SNK_W), .DEPTH(MAX_EDITS + 1)) u_snake_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    ovf_nxt       = ovf_r;
    lim_nxt       = lim_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    base_nxt      = base_r;
    bt_nxt        = bt_r;
    oka_nxt       = oka_r;
    okb_nxt       = okb_r;
    va_nxt        = va_r;
    prefix_nxt    = prefix_r;
    dist_nxt      = dist_r;
    ready_nxt     = ready_r;
    cp_nxt        = cp_r;
    right_nxt     = right_r;
    seg_nxt       = seg_r;
    edits_nxt     = edits_r;
    rem_nxt       = rem_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    adv_nxt       = adv_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rem_post      = rem_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            OP_CLEAR: begin
              n_nxt     = '0;
              m_nxt     = '0;
              ovf_nxt   = 1'b0;
              ready_nxt = 1'b0;
            end
            OP_OLD, OP_NEW: begin
              ready_nxt = 1'b0;
              if (in_data.op == OP_OLD) begin
                if (n_r < CW'(MAX_LEN)) begin
                  n_nxt = n_r + CW'(1);
                end else begin
                  ovf_nxt   = 1'b1;
                  res_nxt   = mk_status(ST_OVERFLOW, '0);
                  adv_nxt   = 1'b0;
                  state_nxt = S_EMIT;
                end
              end else begin
                if (m_r < CW'(MAX_LEN)) begin
                  m_nxt = m_r + CW'(1);
                end else begin
                  ovf_nxt   = 1'b1;
                  res_nxt   = mk_status(ST_OVERFLOW, '0);
                  adv_nxt   = 1'b0;
                  state_nxt = S_EMIT;
                end
              end
            end
            OP_COMPUTE: begin
              ready_nxt = 1'b0;
              adv_nxt   = 1'b0;
              if (ovf_r) begin
                res_nxt   = mk_status(ST_OVERFLOW, '0);
                state_nxt = S_EMIT;
              end else begin
                lim_nxt   = (limit_r > LIM_W'(MAX_EDITS)) ? DW'(MAX_EDITS)
                                                          : DW'(limit_r);
                d_nxt     = '0;
                k_nxt     = '0;
                x_nxt     = '0;
                y_nxt     = '0;
                base_nxt  = '0;
                bt_nxt    = 1'b0;
                state_nxt = S_SNK_RD;
              end
            end
            OP_FETCH: begin
              adv_nxt   = 1'b0;
              state_nxt = S_EMIT;
              if (!ready_r || (!cp_r && rem_r == '0)) begin
                ready_nxt = 1'b0;
                res_nxt   = mk_status(ST_NONE, '0);
              end else begin
                res_nxt.edit_distance = '0;
                res_nxt.status        = ST_OK;
                if (cp_r) begin
                  cp_nxt = 1'b0;
                  if (right_r) begin
                    res_nxt.kind     = KIND_REMOVE;
                    res_nxt.from_pos = from_r;
                    res_nxt.to_pos   = '0;
                    from_nxt         = from_r + AW'(1);
                  end else begin
                    res_nxt.kind     = KIND_ADD;
                    res_nxt.from_pos = '0;
                    res_nxt.to_pos   = to_r;
                    to_nxt           = to_r + AW'(1);
                  end
                end else begin
                  res_nxt.kind     = KIND_EQUAL;
                  res_nxt.from_pos = from_r;
                  res_nxt.to_pos   = to_r;
                  from_nxt         = from_r + AW'(1);
                  to_nxt           = to_r + AW'(1);
                  rem_post         = rem_r - CW'(1);
                  rem_nxt          = rem_post;
                end
                // row run out: either the next snake follows or the script ends
                res_nxt.last = (rem_post == '0) && (seg_r == edits_r);
                adv_nxt      = (rem_post == '0) && (seg_r != edits_r);
                if ((rem_post == '0) && (seg_r == edits_r)) begin
                  ready_nxt = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = adv_r ? S_ADV_RD : S_IDLE;
        end
      end

      S_ADV_RD: begin
        state_nxt = S_ADV_CAP;
      end

      S_ADV_CAP: begin
        seg_nxt   = seg_r + DW'(1);
        cp_nxt    = 1'b1;
        right_nxt = s_rdata[SNK_W-1];
        rem_nxt   = s_rdata[CW-1:0];
        state_nxt = S_IDLE;
      end

      S_RDA: begin
        oka_nxt   = (diag_ix(kk) <= PW'(d_r - DW'(1)));
        state_nxt = S_RDB;
      end

      S_RDB: begin
        va_nxt    = oka_r ? v_rdata : '0;
        okb_nxt   = (diag_ix(kk) <= PW'(d_r - DW'(1)));
        state_nxt = S_SEL;
      end

      S_SEL: begin
        if (!bt_r) begin
          x_nxt     = up ? vb : (va_p + pos_t'(1));
          y_nxt     = (up ? vb : (va_p + pos_t'(1))) - k_r;
          state_nxt = S_SNK_RD;
        end else begin
          lx_nxt   = sx;
          ly_nxt   = sy;
          k_nxt    = k_step;
          base_nxt = prev_base;
          d_nxt    = d_r - DW'(1);
          if (d_r == DW'(1)) begin
            ready_nxt = 1'b1;
            cp_nxt    = 1'b0;
            seg_nxt   = '0;
            edits_nxt = dist_r;
            rem_nxt   = prefix_r;
            from_nxt  = '0;
            to_nxt    = '0;
            res_nxt   = mk_status(ST_OK, dist_r);
            adv_nxt   = (prefix_r == '0);
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_RDA;
          end
        end
      end

      S_SNK_RD: begin
        state_nxt = in_rng ? S_SNK_CMP : S_VWR;
      end

      S_SNK_CMP: begin
        if (old_rdata == new_rdata) begin
          x_nxt     = x_r + pos_t'(1);
          y_nxt     = y_r + pos_t'(1);
          state_nxt = S_SNK_RD;
        end else begin
          state_nxt = S_VWR;
        end
      end

      S_VWR: begin
        if (d_r == '0) begin
          prefix_nxt = x_r[CW-1:0];
        end
        if ((x_r == ext_cnt(n_r)) && (y_r == ext_cnt(m_r))) begin
          dist_nxt = d_r;
          lx_nxt   = ext_cnt(n_r);
          ly_nxt   = ext_cnt(m_r);
          k_nxt    = ext_cnt(n_r) - ext_cnt(m_r);
          bt_nxt   = 1'b1;
          if (d_r == '0) begin
            ready_nxt = 1'b1;
            cp_nxt    = 1'b0;
            seg_nxt   = '0;
            edits_nxt = '0;
            rem_nxt   = x_r[CW-1:0];
            from_nxt  = '0;
            to_nxt    = '0;
            res_nxt   = mk_status(ST_OK, '0);
            adv_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_RDA;
          end
        end else if (k_r == ext_d(d_r)) begin
          if (d_r == lim_r) begin
            res_nxt   = mk_status(ST_LIMIT, '0);
            adv_nxt   = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            base_nxt  = base_r + TW'(d_r) + TW'(1);
            d_nxt     = d_r + DW'(1);
            k_nxt     = -(ext_d(d_r) + pos_t'(1));
            state_nxt = S_RDA;
          end
        end else begin
          k_nxt     = k_r + pos_t'(2);
          state_nxt = S_RDA;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIM_W'(256);
      n_r         <= '0;
      m_r         <= '0;
      ovf_r       <= 1'b0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      n_r         <= n_nxt;
      m_r         <= m_nxt;
      ovf_r       <= ovf_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    d_r      <= d_nxt;
    k_r      <= k_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    lx_r     <= lx_nxt;
    ly_r     <= ly_nxt;
    base_r   <= base_nxt;
    bt_r     <= bt_nxt;
    oka_r    <= oka_nxt;
    okb_r    <= okb_nxt;
    va_r     <= va_nxt;
    prefix_r <= prefix_nxt;
    dist_r   <= dist_nxt;
    cp_r     <= cp_nxt;
    right_r  <= right_nxt;
    seg_r    <= seg_nxt;
    edits_r  <= edits_nxt;
    rem_r    <= rem_nxt;
    from_r   <= from_nxt;
    to_r     <= to_nxt;
    adv_r    <= adv_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  `MSES_AST_NOW(a_no_script_in_search, state_r == S_SNK_RD, !ready_r,
                "script marked ready during search")
  `MSES_AST_NOW(a_vwr_in_table, state_r == S_VWR, v_waddr < TW'(TBL_DEPTH),
                "furthest-x write beyond table")
  `MSES_AST_NXT(a_compute_busy, accept && in_data.op == OP_COMPUTE, state_r != S_IDLE,
                "compute did not start")
  `MSES_AST_NXT(a_emit_loads, state_r == S_EMIT && out_free, out_valid_r,
                "pending result not loaded")

endmodule
